/* hdl/lsab_pkg.sv */
// Shared constants, types and helper functions for the lidar angular binner.
// Used by the channel interfaces, the bin mapper and the top level.
package lsab_pkg;

    localparam int MAX_BINS = 1024;
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int ADDR_W   = BIN_W + 1;            // bank bit and bin number

    // The written flags are kept as rows of ROW_BITS bins with one valid flop per row.
    localparam int ROW_BITS  = 32;
    localparam int COL_W     = (BIN_W < 5) ? BIN_W : 5;
    localparam int ROW_IDX_W = ADDR_W - COL_W;
    localparam int NUM_ROWS  = 2 ** ROW_IDX_W;

    // Fixed field widths.
    localparam int NBINS_W = 11;
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int INTEN_W = 8;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Angle arithmetic: one turn is 360 degrees times 64.
    localparam logic [ANGLE_W-1:0] FULL_TURN_Q6 = 15'd23040;
    localparam int PROD_W     = ANGLE_W + NBINS_W;
    localparam int HALF_TURN  = 11520;
    localparam int DIV_SHIFT  = 9;                   // 23040 = 512 * 45
    localparam int DIV_K      = 45;
    localparam int Y_W        = PROD_W - DIV_SHIFT;
    localparam int RECIP_W    = 16;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP      = 46604;               // ceil(2^21 / 45)
    localparam int QP_W       = Y_W + RECIP_W;
    localparam int QE_W       = QP_W - RECIP_SHIFT;
    localparam int QK_W       = QE_W + 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 3'd3;

    typedef struct packed {
        logic               command;
        logic               rev_start;
        logic               pt_ok;
        logic [DIST_W-1:0]  distance;
        logic [INTEN_W-1:0] intensity;
        logic [IDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0]  range;
        logic [INTEN_W-1:0] intensity;
    } t_entry;

    typedef struct packed {
        logic ld_b;
        logic ld_c;
    } t_pipe_en;

    // Number of bins in use: zero acts as one, anything above MAX_BINS as MAX_BINS.
    function automatic logic [NBINS_W-1:0] active_bins(input logic [NBINS_W-1:0] count);
        logic [NBINS_W-1:0] res;
        if (count == '0) begin
            res = NBINS_W'(1);
        end else if (count > NBINS_W'(MAX_BINS)) begin
            res = NBINS_W'(MAX_BINS);
        end else begin
            res = count;
        end
        return res;
    endfunction

endpackage

/* hdl/lsab_ifs.sv */
// Valid/ready channel interfaces for the binner: point/read input, result output
// and configuration writes. Depends on lsab_pkg for field widths.
interface lsab_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic                        rev_start;
    logic [lsab_pkg::ANGLE_W-1:0] angle_q6;
    logic [lsab_pkg::DIST_W-1:0]  distance_qmm;
    logic [lsab_pkg::INTEN_W-1:0] point_intensity;
    logic [lsab_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, command, rev_start, angle_q6, distance_qmm,
                    point_intensity, read_index, input ready);
    modport sink   (input valid, command, rev_start, angle_q6, distance_qmm,
                    point_intensity, read_index, output ready);
endinterface

interface lsab_out_if;
    logic                         valid;
    logic                         ready;
    logic                         scan_published;
    logic                         scan_dropped;
    logic                         scan_available;
    logic [lsab_pkg::DIST_W-1:0]  bin_range;
    logic [lsab_pkg::INTEN_W-1:0] bin_intensity;
    logic                         bin_empty;

    modport source (output valid, scan_published, scan_dropped, scan_available,
                    bin_range, bin_intensity, bin_empty, input ready);
    modport sink   (input valid, scan_published, scan_dropped, scan_available,
                    bin_range, bin_intensity, bin_empty, output ready);
endinterface

interface lsab_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lsab_pkg::CFG_IDX_W-1:0]  index;
    logic [lsab_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lidar_scan_angular_binner.sv */
// Top level of the lidar angular binner: pipeline control, bank state and the
// two bin memories. Depends on lsab_pkg, lsab_ifs and lsab_bin_map.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  i_pt     | in  | command, rev_start, angle_q6, distance_qmm, intensity, index
//  o_res    | out | scan_published, scan_dropped, scan_available, bin fields
//  i_cfg    | in  | register index and data, always ready
//
// One beat is accepted per cycle while the output is not stalled; its result leaves
// through an output register (input stage, multiply, divide, memory read, update).
// Each beat reads the entry memory and the flag memory; a point that updates its bin writes both back;
// a hit on the entry still being written is forwarded. Bank clears need no sweep:
// per-row valid flops are cleared at once, and reset needs no sweep either.
// A stalled output holds its beat while the stages behind it keep filling.
module lidar_scan_angular_binner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsab_in_if.sink     i_pt,
    lsab_out_if.source  o_res,
    lsab_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [lsab_pkg::NBINS_W-1:0] r_bin_count;
    logic                         r_mirror;
    logic [lsab_pkg::CNT_W-1:0]   r_min_pts;
    logic [lsab_pkg::CNT_W-1:0]   r_max_pts;
    logic [lsab_pkg::NBINS_W-1:0] w_nbins;

    // Scan state.
    logic                         r_fill_bank;
    logic [lsab_pkg::CNT_W-1:0]   r_pt_count;
    logic                         r_any_pub;
    logic [lsab_pkg::NUM_ROWS-1:0] r_row_valid;

    // Pipeline.
    logic                         r_va, r_vb, r_vc, r_vd, r_vo;
    logic                         w_ld_a, w_ld_b, w_ld_c, w_ld_d, w_adv_d;
    lsab_pkg::t_pipe_en           w_en;
    lsab_pkg::t_item              r_a_item, r_b_item, r_c_item;
    logic [lsab_pkg::ANGLE_W-1:0] r_a_angle;
    logic [lsab_pkg::BIN_W-1:0]   w_bin;

    // Control stage.
    logic                          w_is_pt, w_close, w_pub, w_fb_new, w_drop, w_clear;
    logic [lsab_pkg::CNT_W-1:0]    w_cnt1;
    logic                          w_bank;
    logic [lsab_pkg::BIN_W-1:0]    w_bin_sel;
    logic [lsab_pkg::ADDR_W-1:0]   w_addr;
    logic [lsab_pkg::ROW_IDX_W-1:0] w_row;
    logic                          w_in_range;

    // Update stage.
    logic                          r_d_is_read, r_d_pub, r_d_drop, r_d_avail;
    logic                          r_d_in_range, r_d_binning;
    logic [lsab_pkg::ADDR_W-1:0]   r_d_addr;
    logic [lsab_pkg::DIST_W-1:0]   r_d_dist;
    logic [lsab_pkg::INTEN_W-1:0]  r_d_inten;
    logic                          r_d_fwd_ent, r_d_fwd_row;
    lsab_pkg::t_entry              r_d_fwd_data;
    logic [lsab_pkg::ROW_BITS-1:0] r_d_fwd_word;
    logic [lsab_pkg::ROW_IDX_W-1:0] w_d_row;
    logic [lsab_pkg::COL_W-1:0]    w_d_col;
    logic                          w_row_ok, w_bit, w_d_upd, w_d_we;
    logic [lsab_pkg::ROW_BITS-1:0] w_word_old, w_new_word;
    lsab_pkg::t_entry              w_ent, w_new_ent;
    logic                          w_empty;

    // Memories.
    lsab_pkg::t_entry              r_ent_mem [2*lsab_pkg::MAX_BINS];
    logic [lsab_pkg::ROW_BITS-1:0] r_flag_mem [lsab_pkg::NUM_ROWS];
    lsab_pkg::t_entry              r_ent_q;
    logic [lsab_pkg::ROW_BITS-1:0] r_flag_q;

    // Output register.
    logic                          r_o_pub, r_o_drop, r_o_avail, r_o_empty;
    logic [lsab_pkg::DIST_W-1:0]   r_o_range;
    logic [lsab_pkg::INTEN_W-1:0]  r_o_inten;

    logic                          w_fill_rows_any;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= lsab_pkg::NBINS_W'(360);
            r_mirror    <= 1'b1;
            r_min_pts   <= lsab_pkg::CNT_W'(100);
            r_max_pts   <= lsab_pkg::CNT_W'(4000);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lsab_pkg::CFG_BIN_COUNT:  r_bin_count <= i_cfg.data[lsab_pkg::NBINS_W-1:0];
                lsab_pkg::CFG_MIRROR:     r_mirror    <= i_cfg.data[0];
                lsab_pkg::CFG_MIN_POINTS: r_min_pts   <= i_cfg.data[lsab_pkg::CNT_W-1:0];
                lsab_pkg::CFG_MAX_POINTS: r_max_pts   <= i_cfg.data[lsab_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_nbins = lsab_pkg::active_bins(r_bin_count);

    // ------------------------------------------------------- pipeline control
    assign w_adv_d = r_vd && (!r_vo || o_res.ready);
    assign w_ld_d  = r_vc && (!r_vd || w_adv_d);
    assign w_ld_c  = r_vb && (!r_vc || w_ld_d);
    assign w_ld_b  = r_va && (!r_vb || w_ld_c);
    assign i_pt.ready = !r_va || w_ld_b;
    assign w_ld_a  = i_pt.valid && i_pt.ready;
    assign w_en    = '{ld_b: w_ld_b, ld_c: w_ld_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_va <= w_ld_a || (r_va && !w_ld_b);
            r_vb <= w_ld_b || (r_vb && !w_ld_c);
            r_vc <= w_ld_c || (r_vc && !w_ld_d);
            r_vd <= w_ld_d || (r_vd && !w_adv_d);
            r_vo <= w_adv_d || (r_vo && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a) begin
            r_a_angle           <= i_pt.angle_q6;
            r_a_item.command    <= i_pt.command;
            r_a_item.rev_start  <= i_pt.rev_start;
            r_a_item.pt_ok      <= (i_pt.distance_qmm != '0) &&
                                   (i_pt.angle_q6 < lsab_pkg::FULL_TURN_Q6);
            r_a_item.distance   <= i_pt.distance_qmm;
            r_a_item.intensity  <= i_pt.point_intensity;
            r_a_item.read_index <= i_pt.read_index;
        end
        if (w_ld_b) begin
            r_b_item <= r_a_item;
        end
        if (w_ld_c) begin
            r_c_item <= r_b_item;
        end
    end

    lsab_bin_map u_bin_map (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_angle  (r_a_angle),
        .i_mirror (r_mirror),
        .i_nbins  (w_nbins),
        .o_bin    (w_bin)
    );

    // ---------------------------------------------------------- control stage
    // A revolution start closes a non-empty scan before the point is binned.
    always_comb begin
        w_is_pt   = !r_c_item.command;
        w_close   = r_c_item.rev_start && (r_pt_count != '0);
        w_pub     = w_close && (r_pt_count >= r_min_pts);
        w_fb_new  = r_fill_bank ^ w_pub;
        w_cnt1    = w_close ? '0 : r_pt_count;
        w_drop    = w_cnt1 >= r_max_pts;
        w_clear   = w_ld_d && w_is_pt && (w_close || w_drop);
        w_bank    = w_is_pt ? w_fb_new : !r_fill_bank;
        w_bin_sel = w_is_pt ? w_bin : lsab_pkg::BIN_W'(r_c_item.read_index);
        w_addr    = {w_bank, w_bin_sel};
        w_row     = w_addr[lsab_pkg::ADDR_W-1:lsab_pkg::COL_W];
        w_in_range = lsab_pkg::NBINS_W'(r_c_item.read_index) < w_nbins;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank <= 1'b0;
            r_pt_count  <= '0;
            r_any_pub   <= 1'b0;
        end else if (w_ld_d && w_is_pt) begin
            r_fill_bank <= w_fb_new;
            r_pt_count  <= w_drop ? '0 : w_cnt1 + lsab_pkg::CNT_W'(1);
            r_any_pub   <= r_any_pub || w_pub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_d) begin
            r_d_is_read  <= r_c_item.command;
            r_d_pub      <= w_is_pt && w_pub;
            r_d_drop     <= w_is_pt && w_drop;
            r_d_avail    <= r_any_pub || (w_is_pt && w_pub);
            r_d_in_range <= w_in_range;
            r_d_binning  <= w_is_pt && !w_drop && r_c_item.pt_ok;
            r_d_addr     <= w_addr;
            r_d_dist     <= r_c_item.distance;
            r_d_inten    <= r_c_item.intensity;
            // The memories return old data when the beat ahead writes the same place.
            r_d_fwd_ent  <= w_d_we && (r_d_addr == w_addr);
            r_d_fwd_row  <= w_d_we && (w_d_row == w_row);
            r_d_fwd_data <= w_new_ent;
            r_d_fwd_word <= w_new_word;
        end
    end

    // --------------------------------------------------------------- memories
    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            r_ent_mem[r_d_addr] <= w_new_ent;
        end
        if (w_ld_d) begin
            r_ent_q <= r_ent_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            r_flag_mem[w_d_row] <= w_new_word;
        end
        if (w_ld_d) begin
            r_flag_q <= r_flag_mem[w_row];
        end
    end

    // ----------------------------------------------------------- update stage
    always_comb begin
        w_d_row    = r_d_addr[lsab_pkg::ADDR_W-1:lsab_pkg::COL_W];
        w_d_col    = r_d_addr[lsab_pkg::COL_W-1:0];
        w_row_ok   = r_row_valid[w_d_row];
        w_word_old = r_d_fwd_row ? r_d_fwd_word : r_flag_q;
        w_bit      = w_row_ok && w_word_old[w_d_col];
        w_ent      = r_d_fwd_ent ? r_d_fwd_data : r_ent_q;
        w_d_upd    = r_vd && r_d_binning && (!w_bit || (r_d_dist < w_ent.range));
        w_d_we     = w_adv_d && w_d_upd;
        w_new_ent  = '{range: r_d_dist, intensity: r_d_inten};
        w_new_word = (w_row_ok ? w_word_old : '0) |
                     (lsab_pkg::ROW_BITS'(1) << w_d_col);
        w_empty    = !(r_d_in_range && w_bit);
    end

    // A bank clear in the control stage wins over a row set by the older beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else begin
            for (int r = 0; r < lsab_pkg::NUM_ROWS; r++) begin
                if (w_clear && (r[lsab_pkg::ROW_IDX_W-1] == w_fb_new)) begin
                    r_row_valid[r] <= 1'b0;
                end else if (w_d_we && (w_d_row == lsab_pkg::ROW_IDX_W'(r))) begin
                    r_row_valid[r] <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (w_adv_d) begin
            r_o_pub   <= r_d_pub;
            r_o_drop  <= r_d_drop;
            r_o_avail <= r_d_avail;
            r_o_empty <= r_d_is_read && w_empty;
            if (r_d_is_read && !w_empty) begin
                r_o_range <= w_ent.range;
                r_o_inten <= w_ent.intensity;
            end else begin
                r_o_range <= '0;
                r_o_inten <= '0;
            end
        end
    end

    assign o_res.valid          = r_vo;
    assign o_res.scan_published = r_o_pub;
    assign o_res.scan_dropped   = r_o_drop;
    assign o_res.scan_available = r_o_avail;
    assign o_res.bin_range      = r_o_range;
    assign o_res.bin_intensity  = r_o_inten;
    assign o_res.bin_empty      = r_o_empty;

    always_comb begin
        w_fill_rows_any = 1'b0;
        for (int r = 0; r < lsab_pkg::NUM_ROWS; r++) begin
            if (r[lsab_pkg::ROW_IDX_W-1] == r_fill_bank) begin
                w_fill_rows_any = w_fill_rows_any || r_row_valid[r];
            end
        end
    end

    // -------------------------------------------------------------- checks
`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd && !w_adv_d) |-> !w_ld_d)
        else $error("control stage loaded over a held update beat");

    a_avail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_pub |=> r_any_pub)
        else $error("scan available flag fell");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_o_empty) |-> ((r_o_range == '0) && (r_o_inten == '0)))
        else $error("empty bin read carries data");

    a_clear_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> !w_fill_rows_any)
        else $error("fill bank still holds rows after a clear");
`endif

endmodule

/* hdl/lsab_bin_map.sv */
// Angle to bin pipeline: mirror and scale by the bin count, then divide by a
// full turn with a reciprocal multiply. Depends on lsab_pkg.
module lsab_bin_map (
    input  logic                            i_clk,
    input  lsab_pkg::t_pipe_en              i_en,
    input  logic [lsab_pkg::ANGLE_W-1:0]    i_angle,
    input  logic                            i_mirror,
    input  logic [lsab_pkg::NBINS_W-1:0]    i_nbins,
    output logic [lsab_pkg::BIN_W-1:0]      o_bin
);

    logic [lsab_pkg::ANGLE_W-1:0] w_angle;
    logic [lsab_pkg::PROD_W-1:0]  r_prod;
    logic [lsab_pkg::PROD_W-1:0]  w_sum;
    logic [lsab_pkg::Y_W-1:0]     w_y;
    logic [lsab_pkg::QP_W-1:0]    w_qprod;
    logic [lsab_pkg::Y_W-1:0]     r_y;
    logic [lsab_pkg::QE_W-1:0]    r_qe;
    logic [lsab_pkg::QK_W-1:0]    w_qk;
    logic [lsab_pkg::QE_W-1:0]    w_q;

    // Mirroring maps zero onto itself rather than onto a full turn.
    always_comb begin
        if (i_mirror && (i_angle != '0)) begin
            w_angle = lsab_pkg::FULL_TURN_Q6 - i_angle;
        end else begin
            w_angle = i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_b) begin
            r_prod <= lsab_pkg::PROD_W'(w_angle) * lsab_pkg::PROD_W'(i_nbins);
        end
    end

    assign w_sum   = r_prod + lsab_pkg::PROD_W'(lsab_pkg::HALF_TURN);
    assign w_y     = w_sum[lsab_pkg::PROD_W-1:lsab_pkg::DIV_SHIFT];
    assign w_qprod = lsab_pkg::QP_W'(w_y) * lsab_pkg::QP_W'(lsab_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.ld_c) begin
            r_y  <= w_y;
            r_qe <= w_qprod[lsab_pkg::QP_W-1:lsab_pkg::RECIP_SHIFT];
        end
    end

    // The rounded-up reciprocal can overshoot the quotient by one.
    assign w_qk = lsab_pkg::QK_W'(r_qe) * lsab_pkg::QK_W'(lsab_pkg::DIV_K);

    always_comb begin
        if (w_qk > lsab_pkg::QK_W'(r_y)) begin
            w_q = r_qe - lsab_pkg::QE_W'(1);
        end else begin
            w_q = r_qe;
        end
        if (w_q >= lsab_pkg::QE_W'(i_nbins)) begin
            o_bin = '0;
        end else begin
            o_bin = w_q[lsab_pkg::BIN_W-1:0];
        end
    end

endmodule
